// ===== rtl/prm_pkg.sv =====
// Shared types, constants and match functions for the polygon rule match router.
package prm_pkg;

   localparam int RULES = 16;

   localparam int ACT_W          = 7;
   localparam int ACT_TO_HUD_BIT = 0;
   localparam int ACT_START_HUD_BIT = 1;

   localparam logic [15:0] TOL_RESET = 16'd66;

   typedef enum logic [1:0] {
      CMD_MATCH    = 2'd0,
      CMD_LOAD     = 2'd1,
      CMD_NEWFRAME = 2'd2,
      CMD_CLEAR    = 2'd3
   } command_type;

   typedef struct packed {
      command_type        command;
      logic [3:0]         rule_index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [15:0]        vertex_count;
      logic [31:0]        tex_hash;
      logic [3:0]         care_mask;
      logic [ACT_W-1:0]   rule_actions;
   } item_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [15:0]        vertex_count;
      logic [31:0]        tex_hash;
      logic [3:0]         care_mask;
      logic [ACT_W-1:0]   rule_actions;
   } rule_type;

   // The difference is formed in 33 bits so it never wraps.
   function automatic logic coord_close(logic signed [31:0] a, logic signed [31:0] b,
                                        logic [15:0] tol);
      logic signed [32:0] diff;
      logic [32:0]        mag;
      diff = {a[31], a} - {b[31], b};
      mag  = diff[32] ? 33'(-diff) : 33'(diff);
      return mag <= {17'd0, tol};
   endfunction

   function automatic logic rule_hit(rule_type r, item_type p, logic [15:0] tol);
      logic ok;
      ok = 1'b1;
      if (r.care_mask[0] && !coord_close(p.pos_x, r.pos_x, tol)) ok = 1'b0;
      if (r.care_mask[1] && !coord_close(p.pos_y, r.pos_y, tol)) ok = 1'b0;
      if (r.care_mask[2] && !coord_close(p.pos_z, r.pos_z, tol)) ok = 1'b0;
      if (r.care_mask[3] && (p.vertex_count != r.vertex_count)) ok = 1'b0;
      if ((r.tex_hash != 32'd0) && (p.tex_hash != r.tex_hash)) ok = 1'b0;
      return ok;
   endfunction

endpackage

// ===== rtl/prm_req_if.sv =====
// Request channel: one command beat with polygon or rule payload.
interface prm_req_if;
   logic                        valid;
   logic                        ready;
   prm_pkg::command_type        command;
   logic [3:0]                  rule_index;
   logic signed [31:0]          pos_x;
   logic signed [31:0]          pos_y;
   logic signed [31:0]          pos_z;
   logic [15:0]                 vertex_count;
   logic [31:0]                 tex_hash;
   logic [3:0]                  care_mask;
   logic [prm_pkg::ACT_W-1:0]   rule_actions;

   modport source (output valid, command, rule_index, pos_x, pos_y, pos_z, vertex_count,
                   tex_hash, care_mask, rule_actions, input ready);
   modport sink   (input valid, command, rule_index, pos_x, pos_y, pos_z, vertex_count,
                   tex_hash, care_mask, rule_actions, output ready);
endinterface

// ===== rtl/prm_rsp_if.sv =====
// Response channel: one beat of match actions per polygon.
interface prm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [prm_pkg::ACT_W-1:0]   actions;
   logic                        hud_active;

   modport source (output valid, actions, hud_active, input ready);
   modport sink   (input valid, actions, hud_active, output ready);
endinterface

// ===== rtl/prm_csr_if.sv =====
// Configuration write channel for the match tolerance register.
interface prm_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] match_tolerance;

   modport source (output valid, match_tolerance, input ready);
   modport sink   (input valid, match_tolerance, output ready);
endinterface

// ===== rtl/polygon_rule_match_router.sv =====
// A match beat is held in the stage 1 register, then its response in the response register.
// Throughput: one request beat per cycle unless a match beat waits on a held response;
// every rule lane compares in parallel between the input register and the response register.
// Load, new frame and clear beats retire without waiting on the response slot and produce no response.
// Reset (synchronous) clears the rule valid bits, the HUD flag, both stage valids
// and sets the tolerance to 66; rule contents stay undefined until loaded.
module polygon_rule_match_router (
   input logic     clock,
   input logic     reset,
   prm_req_if.sink req,
   prm_rsp_if.source rsp,
   prm_csr_if.sink csr
);
   import prm_pkg::*;

   logic [15:0]      tol_ff;
   logic             s1_vld_ff, s1_vld_in;
   item_type         s1_ff;
   item_type         req_item;
   rule_type         table_ff [RULES];
   logic [RULES-1:0] valid_ff, valid_in;
   logic [RULES-1:0] lane_hit;
   logic             hud_ff, hud_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [ACT_W-1:0] rsp_act_ff, rsp_act_in;
   logic             rsp_hud_ff;
   logic [ACT_W-1:0] acts_or;
   logic             out_free, s1_go, s1_is_match;

   assign req_item = '{command: req.command, rule_index: req.rule_index, pos_x: req.pos_x,
                       pos_y: req.pos_y, pos_z: req.pos_z, vertex_count: req.vertex_count,
                       tex_hash: req.tex_hash, care_mask: req.care_mask,
                       rule_actions: req.rule_actions};

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr.valid) begin
         tol_ff <= csr.match_tolerance;
      end
   end

   // Stage 1 retires when it holds a beat with no response or the response slot frees up.
   assign s1_is_match = (s1_ff.command == CMD_MATCH);
   assign out_free    = !rsp_vld_ff || rsp.ready;
   assign s1_go       = s1_vld_ff && (!s1_is_match || out_free);
   assign req.ready   = !s1_vld_ff || s1_go;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req.valid && req.ready) begin
         s1_vld_in = 1'b1;
      end else if (s1_go) begin
         s1_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_ff <= req_item;
      end
   end

   // One compare lane per rule slot.
   for (genvar i = 0; i < RULES; i++) begin : g_lane
      assign lane_hit[i] = valid_ff[i] && rule_hit(table_ff[i], s1_ff, tol_ff);

      always_ff @(posedge clock) begin
         if (s1_go && (s1_ff.command == CMD_LOAD) && (32'(s1_ff.rule_index) == i)) begin
            table_ff[i] <= '{pos_x: s1_ff.pos_x, pos_y: s1_ff.pos_y, pos_z: s1_ff.pos_z,
                             vertex_count: s1_ff.vertex_count, tex_hash: s1_ff.tex_hash,
                             care_mask: s1_ff.care_mask, rule_actions: s1_ff.rule_actions};
         end
      end
   end

   always_comb begin
      acts_or = '0;
      for (int i = 0; i < RULES; i++) begin
         if (lane_hit[i]) begin
            acts_or = acts_or | table_ff[i].rule_actions;
         end
      end
   end

   always_comb begin
      valid_in   = valid_ff;
      hud_in     = hud_ff;
      rsp_act_in = acts_or;
      if (s1_go) begin
         case (s1_ff.command)
            CMD_LOAD: begin
               for (int i = 0; i < RULES; i++) begin
                  if (32'(s1_ff.rule_index) == i) begin
                     valid_in[i] = 1'b1;
                  end
               end
            end
            CMD_NEWFRAME: begin
               hud_in = 1'b0;
            end
            CMD_CLEAR: begin
               valid_in = '0;
            end
            CMD_MATCH: begin
               hud_in = hud_ff || acts_or[ACT_START_HUD_BIT];
            end
            default: begin
               hud_in = hud_ff;
            end
         endcase
      end
      rsp_act_in[ACT_TO_HUD_BIT] = acts_or[ACT_TO_HUD_BIT] || hud_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hud_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hud_ff   <= hud_in;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff && !rsp.ready;
      if (s1_go && s1_is_match) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_is_match) begin
         rsp_act_ff <= rsp_act_in;
         rsp_hud_ff <= hud_in;
      end
   end

   assign rsp.valid      = rsp_vld_ff;
   assign rsp.actions    = rsp_act_ff;
   assign rsp.hud_active = rsp_hud_ff;

`ifndef ASSERT_OFF
   a_rsp_from_match: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(s1_vld_ff && s1_is_match))
      else $error("response appeared without a match beat in stage 1");

   a_hud_forces_to_hud: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_hud_ff) |-> rsp_act_ff[ACT_TO_HUD_BIT])
      else $error("HUD active response lacks the to-HUD action");

   a_start_sets_hud: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_act_ff[ACT_START_HUD_BIT]) |-> rsp_hud_ff)
      else $error("start-HUD action did not raise the HUD flag");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (s1_go && (s1_ff.command == CMD_CLEAR)) |=> (valid_ff == '0))
      else $error("rule table not empty after clear");

   a_newframe_drops_hud: assert property (@(posedge clock) disable iff (reset)
      (s1_go && (s1_ff.command == CMD_NEWFRAME)) |=> !hud_ff)
      else $error("HUD flag survived a new frame");
`endif

endmodule
